// ===== rtl/core/utf16_byte_stream_decoder_macros.svh =====
// Assertion macros shared by the UTF-16 byte stream decoder modules.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef UTF16_BYTE_STREAM_DECODER_MACROS_SVH
`define UTF16_BYTE_STREAM_DECODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define U16BSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define U16BSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/u16bsd_pkg.sv =====
// Shared types and constants of the UTF-16 byte stream decoder.
// No dependencies; used by front, queue, back and top level.
`timescale 1ns / 1ps

package u16bsd_pkg;

  localparam int COUNT_BITS = 24;
  localparam int CP_BITS    = 21;
  localparam int SLOTS      = 3;

  localparam int SLOT_A    = 0;
  localparam int SLOT_B    = 1;
  localparam int SLOT_TERM = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [5:0]          HIGH_TAG  = 6'b110110;
  localparam logic [5:0]          LOW_TAG   = 6'b110111;
  localparam logic [CP_BITS-1:0]  SUPP_BASE = 21'h10000;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [SLOTS-1:0]   slots;
    logic [CP_BITS-1:0] cp_a;
    logic [CP_BITS-1:0] cp_b;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ===== rtl/core/u16bsd_front.sv =====
// Front end: pairs bytes into code units, matches surrogates, builds queue entries.
// Depends on u16bsd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "utf16_byte_stream_decoder_macros.svh"

module u16bsd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,  // [7:0] data_byte
  input  logic                s_tlast,  // end_of_text
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                q_full,
  output u16bsd_pkg::push_t   push
);

  logic       big_endian;
  logic [7:0] held_byte;
  logic       byte_waiting;
  logic [9:0] high_bits;
  logic       high_waiting;

  logic [7:0] held_byte_next;
  logic       byte_waiting_next;
  logic [9:0] high_bits_next;
  logic       high_waiting_next;

  logic        accept;
  logic [15:0] unit;
  logic        is_high;
  logic        is_low;
  logic        pair;
  logic        unit_out;
  logic [9:0]  hb_mid;
  logic        hw_mid;
  u16bsd_pkg::entry_t entry;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign unit    = big_endian ? {held_byte, s_tdata} : {s_tdata, held_byte};
  assign is_high = (unit[15:10] == u16bsd_pkg::HIGH_TAG);
  assign is_low  = (unit[15:10] == u16bsd_pkg::LOW_TAG);
  assign pair    = byte_waiting && high_waiting && is_low;

  assign unit_out = byte_waiting && !pair && !is_high;
  assign hb_mid   = (byte_waiting && !pair && is_high) ? unit[9:0] : high_bits;
  assign hw_mid   = byte_waiting ? (!pair && is_high) : high_waiting;

  always_comb begin
    entry = '0;
    if (pair) begin
      entry.slots[u16bsd_pkg::SLOT_A] = 1'b1;
      entry.cp_a = u16bsd_pkg::SUPP_BASE + {1'b0, high_bits, unit[9:0]};
    end else if (byte_waiting && high_waiting) begin
      entry.slots[u16bsd_pkg::SLOT_A] = 1'b1;
      entry.cp_a = {5'd0, u16bsd_pkg::HIGH_TAG, high_bits};
    end
    if (unit_out) begin
      entry.slots[u16bsd_pkg::SLOT_B] = 1'b1;
      entry.cp_b = {5'd0, unit};
    end else if (s_tlast && hw_mid) begin
      entry.slots[u16bsd_pkg::SLOT_B] = 1'b1;
      entry.cp_b = {5'd0, u16bsd_pkg::HIGH_TAG, hb_mid};
    end
    entry.slots[u16bsd_pkg::SLOT_TERM] = s_tlast;
  end

  assign push.valid = accept && (entry.slots != '0);
  assign push.entry = entry;

  always_comb begin
    held_byte_next    = byte_waiting ? held_byte : s_tdata;
    byte_waiting_next = !byte_waiting;
    high_bits_next    = hb_mid;
    high_waiting_next = hw_mid;
    if (s_tlast) begin
      held_byte_next    = '0;
      byte_waiting_next = 1'b0;
      high_bits_next    = '0;
      high_waiting_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian   <= 1'b0;
      held_byte    <= '0;
      byte_waiting <= 1'b0;
      high_bits    <= '0;
      high_waiting <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        big_endian <= cfg_wr_data;
      end
      if (accept) begin
        held_byte    <= held_byte_next;
        byte_waiting <= byte_waiting_next;
        high_bits    <= high_bits_next;
        high_waiting <= high_waiting_next;
      end
    end
  end

  `U16BSD_ASSERT(a_text_end_clears, accept && s_tlast |=> !byte_waiting && !high_waiting, "front state not cleared after end of text")

endmodule

// ===== rtl/core/u16bsd_queue.sv =====
// Short entry queue between front and back end.
// Depends on u16bsd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "utf16_byte_stream_decoder_macros.svh"

module u16bsd_queue (
  input  logic               clk,
  input  logic               rst,
  input  u16bsd_pkg::push_t  push,
  output logic               full,
  output u16bsd_pkg::head_t  head,
  input  logic               pop
);

  u16bsd_pkg::entry_t store [u16bsd_pkg::QUEUE_DEPTH];

  logic [u16bsd_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [u16bsd_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [u16bsd_pkg::QPTR_BITS:0]   fill;
  logic                             do_pop;

  assign full       = (fill == (u16bsd_pkg::QPTR_BITS + 1)'(u16bsd_pkg::QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.entry = store[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      store[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!push.valid && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `U16BSD_ASSERT(a_no_overflow, full |-> !push.valid, "queue written while full")

endmodule

// ===== rtl/core/u16bsd_back.sv =====
// Back end: walks the result slots of each queue entry, keeps the character count,
// and holds the output register. Depends on u16bsd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "utf16_byte_stream_decoder_macros.svh"

module u16bsd_back (
  input  logic               clk,
  input  logic               rst,
  input  u16bsd_pkg::head_t  head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [47:0]        m_tdata,  // [20:0] code_point, [44:21] chars_written, pad
  output logic               m_tlast   // is_terminator
);

  logic [u16bsd_pkg::SLOTS-1:0]      consumed;
  logic [u16bsd_pkg::COUNT_BITS-1:0] char_total;
  logic [u16bsd_pkg::CP_BITS-1:0]    code_point;
  logic [u16bsd_pkg::COUNT_BITS-1:0] chars_written;

  logic [u16bsd_pkg::SLOTS-1:0]      remaining;
  logic [u16bsd_pkg::SLOTS-1:0]      pick;
  logic                              entry_done;
  logic                              load;
  logic [u16bsd_pkg::CP_BITS-1:0]    cp_sel;
  logic [u16bsd_pkg::COUNT_BITS-1:0] count_inc;

  assign remaining  = head.entry.slots & ~consumed;
  assign pick       = remaining & (~remaining + 1'b1);
  assign entry_done = ((remaining & ~pick) == '0);
  assign load       = head.valid && (!m_tvalid || m_tready);
  assign pop        = load && entry_done;

  always_comb begin
    cp_sel = '0;
    if (pick[u16bsd_pkg::SLOT_A]) begin
      cp_sel = head.entry.cp_a;
    end else if (pick[u16bsd_pkg::SLOT_B]) begin
      cp_sel = head.entry.cp_b;
    end
  end

  assign count_inc = (char_total == u16bsd_pkg::COUNT_MAX) ? char_total
                                                           : char_total + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      consumed   <= '0;
      char_total <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (load) begin
        consumed <= entry_done ? '0 : (consumed | pick);
        m_tvalid <= 1'b1;
        if (pick[u16bsd_pkg::SLOT_TERM]) begin
          char_total <= '0;
        end else begin
          char_total <= count_inc;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point    <= cp_sel;
      m_tlast       <= pick[u16bsd_pkg::SLOT_TERM];
      chars_written <= pick[u16bsd_pkg::SLOT_TERM] ? char_total : count_inc;
    end
  end

  assign m_tdata = {3'd0, chars_written, code_point};

  `U16BSD_ASSERT(a_term_resets_count, load && pick[u16bsd_pkg::SLOT_TERM] |=> char_total == '0, "count not cleared after terminator")
  `U16BSD_ASSERT(a_consumed_in_entry, head.valid |-> (consumed & ~head.entry.slots) == '0, "slot walk left the head entry")
  `U16BSD_ASSERT(a_one_slot, head.valid |-> $onehot0(pick), "more than one slot picked")

endmodule

// ===== rtl/core/utf16_byte_stream_decoder.sv =====
// UTF-16 byte stream to code point decoder, top level.
// A byte completing a result has its entry written into the queue, and the back end then
// loads that result from the queue head into the output register.
// One byte per cycle is taken while the queue is not full; one result per cycle leaves the
// output register while m_tready is high; a byte can yield up to 3 results, the four-entry
// queue absorbing bursts. Reset (rst, synchronous) clears byte order, pairing, queue, count.
`timescale 1ns / 1ps

module utf16_byte_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [20:0] code_point, [44:21] chars_written, [47:45] zero
  output logic        m_tlast,   // is_terminator
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data  // big_endian
);

  u16bsd_pkg::push_t push;
  u16bsd_pkg::head_t head;
  logic              q_full;
  logic              pop;

  u16bsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push)
  );

  u16bsd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  u16bsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== verif/utf16_byte_stream_decoder_tb.sv =====
// Self-checking testbench for utf16_byte_stream_decoder: directed bytes, then random texts.
// Checks every code point against a byte-level UTF-16 decode kept in the bench.
// Depends on u16bsd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module utf16_byte_stream_decoder_tb;

  localparam logic ORDER_LE = 1'b0;
  localparam logic ORDER_BE = 1'b1;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [u16bsd_pkg::CP_BITS-1:0] PLANE1_BASE = 21'h10000;

  localparam int RANDOM_BYTES = 380;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic { ROW_BYTE, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [7:0]                        data;
    logic                              last;
    logic                              typed;
    logic [u16bsd_pkg::CP_BITS-1:0]    cp;
    logic                              term;
    logic [u16bsd_pkg::COUNT_BITS-1:0] count;
  } stim_row_t;

  typedef struct {
    logic [u16bsd_pkg::CP_BITS-1:0]    cp;
    logic                              term;
    logic [u16bsd_pkg::COUNT_BITS-1:0] count;
  } cp_result_t;

  localparam int DIR_ROWS = 31;
  localparam stim_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'h41, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 21'h41,     1'b0, 24'd1},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 21'h0,      1'b0, 24'd2},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 21'hFFFF,   1'b0, 24'd3},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hDB, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hDF, 1'b0, 1'b1, 21'h10FFFF, 1'b0, 24'd4},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hDC, 1'b0, 1'b1, 21'hDC00,   1'b0, 24'd5},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hD8, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hDB, 1'b0, 1'b1, 21'hD800,   1'b0, 24'd6},
    '{ROW_BYTE, 8'h55, 1'b1, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_CFG,  8'h01, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hD8, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'h3D, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hDE, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 21'h1F600,  1'b0, 24'd1},
    '{ROW_BYTE, 8'h12, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'h34, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'hD8, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'h41, 1'b0, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 21'h0,      1'b0, 24'd0},
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 21'h0,      1'b1, 24'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  logic                              byte_order;
  logic [7:0]                        held_byte;
  logic                              byte_waiting;
  logic [9:0]                        high_bits;
  logic                              high_waiting;
  logic [u16bsd_pkg::COUNT_BITS-1:0] char_total;

  cp_result_t expected_cps[$];
  cp_result_t step_cps[$];
  int         fails = 0;
  int         random_sent = 0;
  int         stall_left = 0;
  bit         no_idle = 1'b0;

  utf16_byte_stream_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void emit_cp(input logic [u16bsd_pkg::CP_BITS-1:0] cp, input logic term);
    cp_result_t res;
    if (!term && char_total != u16bsd_pkg::COUNT_MAX) char_total = char_total + 1'b1;
    res.cp    = cp;
    res.term  = term;
    res.count = char_total;
    step_cps.push_back(res);
  endfunction

  function automatic void clear_text();
    held_byte    = '0;
    byte_waiting = 1'b0;
    high_bits    = '0;
    high_waiting = 1'b0;
    char_total   = '0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [15:0] unit;
    step_cps.delete();
    if (!byte_waiting) begin
      held_byte    = b;
      byte_waiting = 1'b1;
    end else begin
      byte_waiting = 1'b0;
      unit = (byte_order == ORDER_BE) ? {held_byte, b} : {b, held_byte};
      if (high_waiting && unit >= LOW_FIRST && unit <= LOW_LAST) begin
        high_waiting = 1'b0;
        emit_cp(PLANE1_BASE + {1'b0, high_bits, unit[9:0]}, 1'b0);
      end else begin
        if (high_waiting) begin
          high_waiting = 1'b0;
          emit_cp({5'd0, HIGH_FIRST[15:10], high_bits}, 1'b0);
        end
        if (unit >= HIGH_FIRST && unit <= HIGH_LAST) begin
          high_bits    = unit[9:0];
          high_waiting = 1'b1;
        end else begin
          emit_cp({5'd0, unit}, 1'b0);
        end
      end
    end
    if (last) begin
      if (high_waiting) begin
        high_waiting = 1'b0;
        emit_cp({5'd0, HIGH_FIRST[15:10], high_bits}, 1'b0);
      end
      emit_cp('0, 1'b1);
      clear_text();
    end
    foreach (step_cps[i]) expected_cps.push_back(step_cps[i]);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    decode_byte(b, last);
  endtask

  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_byte_order(input logic order);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    byte_order = order;
  endtask

  task automatic push_unit(input logic [15:0] unit, input logic last);
    if (byte_order == ORDER_BE) begin
      push_byte(unit[15:8], 1'b0);
      push_byte(unit[7:0], last);
    end else begin
      push_byte(unit[7:0], 1'b0);
      push_byte(unit[15:8], last);
    end
    random_sent += 2;
  endtask

  task automatic send_text();
    logic [15:0] units[$];
    logic [9:0]  payload;
    bit          odd_tail;
    int          n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      payload = 10'($urandom_range(0, 1023));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: units.push_back(16'($urandom_range(0, 16'hFFFF)));
        4, 5, 6: begin
          units.push_back(HIGH_FIRST | {6'd0, payload});
          units.push_back(LOW_FIRST | {6'd0, 10'($urandom_range(0, 1023))});
        end
        7: units.push_back(HIGH_FIRST | {6'd0, payload});
        8: units.push_back(LOW_FIRST | {6'd0, payload});
        default: begin
          case ($urandom_range(0, 3))
            0: units.push_back(16'h0000);
            1: units.push_back(16'hFFFF);
            2: units.push_back(HIGH_FIRST - 16'd1);
            default: units.push_back(LOW_LAST + 16'd1);
          endcase
        end
      endcase
    end
    odd_tail = ($urandom_range(0, 5) == 0);
    foreach (units[i]) push_unit(units[i], !odd_tail && i == units.size() - 1);
    if (odd_tail) begin
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      random_sent++;
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      push_byte(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 7) == 0));
      random_sent++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cps.size() == 0) begin
        $error("unexpected result: code_point %h", m_tdata[20:0]);
        fails++;
      end else begin
        want = expected_cps.pop_front();
        if (m_tdata[20:0] !== want.cp) begin
          $error("code_point: expected %h, got %h", want.cp, m_tdata[20:0]);
          fails++;
        end
        if (m_tlast !== want.term) begin
          $error("is_terminator: expected %b, got %b", want.term, m_tlast);
          fails++;
        end
        if (m_tdata[44:21] !== want.count) begin
          $error("chars_written: expected %0d, got %0d", want.count, m_tdata[44:21]);
          fails++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int phase_texts;
    byte_order = ORDER_LE;
    clear_text();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        settle_idle();
        set_byte_order(DIR_TABLE[i].data[0]);
      end else begin
        push_byte(DIR_TABLE[i].data, DIR_TABLE[i].last);
        if (DIR_TABLE[i].typed) begin
          if (step_cps.size() != 1) begin
            $error("result count: expected 1, got %0d", step_cps.size());
            fails++;
          end else if (step_cps[0].cp !== DIR_TABLE[i].cp ||
                       step_cps[0].term !== DIR_TABLE[i].term ||
                       step_cps[0].count !== DIR_TABLE[i].count) begin
            $error("directed result: expected %h/%b/%0d, got %h/%b/%0d",
                   DIR_TABLE[i].cp, DIR_TABLE[i].term, DIR_TABLE[i].count,
                   step_cps[0].cp, step_cps[0].term, step_cps[0].count);
            fails++;
          end
        end
      end
    end

    phase_texts = 0;
    while (random_sent < RANDOM_BYTES) begin
      if (phase_texts == 0) begin
        settle_idle();
        no_idle = ($urandom_range(0, 3) == 0);
        set_byte_order($urandom_range(0, 2) == 0 ? byte_order : ~byte_order);
        phase_texts = $urandom_range(2, 6);
      end
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_text();
      phase_texts--;
    end

    s_tvalid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
